FILE: rtl/triangle_wave_channel_unit_macros.svh
// Assertion macros for the triangle wave channel unit.
`ifndef TRIANGLE_WAVE_CHANNEL_UNIT_MACROS_SVH
`define TRIANGLE_WAVE_CHANNEL_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset
`define TWC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("triangle channel check failed");
// Checked on every clock edge, reset included
`define TWC_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("triangle channel check failed");
`else
`define TWC_ASSERT(lbl, prop)
`define TWC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: rtl/twc_pkg.sv
// Shared types and constants of the triangle wave channel unit.
`timescale 1ns / 1ps
`default_nettype none
package twc_pkg;

	localparam int unsigned DIV_W    = 11;
	localparam int unsigned SEQ_W    = 5;
	localparam int unsigned LEVEL_W  = 4;
	localparam int unsigned LININ_W  = 7;
	localparam int unsigned COUNT_W  = 8;
	localparam int unsigned KIND_W   = 4;

	localparam logic [SEQ_W-1:0]   SEQUENCE_START    = 5'd0;
	localparam logic [DIV_W-1:0]   MIN_DIVIDER_RESET = 11'd2;
	localparam logic [COUNT_W-1:0] LINEAR_MAX        = 8'd128;

	// Input word kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_TICK    = 4'd0,
		KIND_QUARTER = 4'd1,
		KIND_HALF    = 4'd2,
		KIND_ENABLE  = 4'd3,
		KIND_DIVIDER = 4'd4,
		KIND_LININIT = 4'd5,
		KIND_HALT    = 4'd6,
		KIND_LENGTH  = 4'd7,
		KIND_RELOAD  = 4'd8
	} kind_t;

	// Result word handed from the channel core to the output register
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               silent;
	} twc_result_t;

endpackage
`default_nettype wire

FILE: rtl/twc_core.sv
// Triangle channel state: timer, sequencer, counters and the next result word.
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_wave_channel_unit_macros.svh"
module twc_core import twc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [DIV_W-1:0]   cfg_data,
	input  wire logic               step,
	input  wire logic [KIND_W-1:0]  kind,
	input  wire logic [DIV_W-1:0]   value,
	output      twc_result_t        result
);

	logic [DIV_W-1:0]   min_div_q;
	logic [DIV_W-1:0]   timer_q,   timer_d;
	logic [SEQ_W-1:0]   seq_q,     seq_d;
	logic               enable_q,  enable_d;
	logic [DIV_W-1:0]   divider_q, divider_d;
	logic               halt_q,    halt_d;
	logic [LININ_W-1:0] lininit_q, lininit_d;
	logic [COUNT_W-1:0] linear_q,  linear_d;
	logic [COUNT_W-1:0] length_q,  length_d;
	logic               silent_cur;
	logic [COUNT_W-1:0] linear_dec;
	logic [COUNT_W-1:0] length_dec;

	// Silence on the state before the word acts
	assign silent_cur = !enable_q || (linear_q == '0) || (length_q == '0) ||
	                    (divider_q < min_div_q);

	// Counter decrements, held by halt or at zero
	assign linear_dec = (!halt_q && linear_q != '0) ? linear_q - 1'b1 : linear_q;
	assign length_dec = (!halt_q && length_q != '0) ? length_q - 1'b1 : length_q;

	// Next state for one word
	always_comb begin
		timer_d   = timer_q;
		seq_d     = seq_q;
		enable_d  = enable_q;
		divider_d = divider_q;
		halt_d    = halt_q;
		lininit_d = lininit_q;
		linear_d  = linear_q;
		length_d  = length_q;
		unique case (kind_t'(kind))
			KIND_TICK: begin
				if (timer_q == '0) begin
					timer_d = divider_q;
					if (!silent_cur)
						seq_d = seq_q + 1'b1;
				end else begin
					timer_d = timer_q - 1'b1;
				end
			end
			KIND_QUARTER: linear_d = linear_dec;
			KIND_HALF: begin
				linear_d = linear_dec;
				length_d = enable_q ? length_dec : '0;
			end
			KIND_ENABLE:  enable_d = value[0];
			KIND_DIVIDER: begin
				divider_d = value;
				timer_d   = value;
			end
			KIND_LININIT: lininit_d = value[LININ_W-1:0];
			KIND_HALT:    halt_d = value[0];
			KIND_LENGTH:  length_d = value[COUNT_W-1:0];
			KIND_RELOAD:  linear_d = {1'b0, lininit_q} + 1'b1;
			default: ;
		endcase
	end

	// Result after the word acts; level folds the index into down then up
	always_comb begin
		result.level  = seq_d[SEQ_W-1] ? seq_d[LEVEL_W-1:0] : ~seq_d[LEVEL_W-1:0];
		result.silent = !enable_d || (linear_d == '0) || (length_d == '0) ||
		                (divider_d < min_div_q);
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_div_q <= MIN_DIVIDER_RESET;
		end else if (cfg_write) begin
			min_div_q <= cfg_data;
		end
	end

	// Channel state, updated once per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q   <= '0;
			seq_q     <= SEQUENCE_START;
			enable_q  <= 1'b0;
			divider_q <= '0;
			halt_q    <= 1'b0;
			lininit_q <= '0;
			linear_q  <= '0;
			length_q  <= '0;
		end else if (step) begin
			timer_q   <= timer_d;
			seq_q     <= seq_d;
			enable_q  <= enable_d;
			divider_q <= divider_d;
			halt_q    <= halt_d;
			lininit_q <= lininit_d;
			linear_q  <= linear_d;
			length_q  <= length_d;
		end
	end

	// Sequence moves only on an accepted tick
	`TWC_ASSERT(a_seq_only_on_tick, !(step && kind == KIND_TICK) |=> $stable(seq_q))
	// The linear counter never exceeds LINEAR_MAX; a reload gives init+1, at most 128
	`TWC_ASSERT_ALWAYS(a_linear_bound, linear_q <= LINEAR_MAX)
	// A silent channel never steps the sequence
	`TWC_ASSERT(a_silent_holds, (step && silent_cur) |=> $stable(seq_q))

endmodule
`default_nettype wire

FILE: rtl/triangle_wave_channel_unit.sv
// Top level of the triangle wave channel unit with its output register.
// The result word of an accepted input word is registered and appears in the next cycle.
// Throughput: one word per cycle while in_stall is low; the output register frees up in the cycle it is taken.
// in_stall is high only while a result word waits and out_stall holds it.
// Reset (arst_n low, asynchronous) clears all channel state, sets min_divider to 2,
// and empties the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_wave_channel_unit_macros.svh"
module triangle_wave_channel_unit import twc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [DIV_W-1:0]   cfg_data,
	input  wire logic               in_valid,
	output      logic               in_stall,
	input  wire logic [KIND_W-1:0]  kind,
	input  wire logic [DIV_W-1:0]   value,
	output      logic               out_valid,
	input  wire logic               out_stall,
	output      logic [LEVEL_W-1:0] level,
	output      logic               is_silent
);

	logic        out_valid_q;
	twc_result_t result_d;
	twc_result_t result_q;
	logic        in_accept;

	// Take a word unless a result is stuck in the output register
	assign in_stall  = out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;

	twc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.step      (in_accept),
		.kind      (kind),
		.value     (value),
		.result    (result_d)
	);

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!in_stall) begin
			out_valid_q <= in_valid;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (in_accept)
			result_q <= result_d;
	end

	assign out_valid = out_valid_q;
	assign level     = result_q.level;
	assign is_silent = result_q.silent;

	// A fresh result word follows an accepted input word
	`TWC_ASSERT(a_out_from_accept, (out_valid && !$past(out_valid && out_stall)) |-> $past(in_valid && !in_stall))
	// No word is taken while a result waits under stall
	`TWC_ASSERT(a_no_overwrite, (out_valid_q && out_stall) |-> !in_accept)

endmodule
`default_nettype wire
